[rtl/core/lpt_pkg.sv]
// Shared types, constants and code points for the lidar point transform.
package lpt_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int COORD_BITS = 20;

  localparam int FIELD_W  = 16;
  localparam int TRIG_W   = 32;
  localparam int CW       = 24;
  localparam int CFG_IDX_W = 3;

  localparam int SINE_LAT    = 7;
  localparam int PIPE_LAT    = 16;
  localparam int WARM_CYCLES = SINE_LAT + 5;
  localparam int WARM_W      = $clog2(WARM_CYCLES + 1);

  localparam longint Q30_ONE  = 64'sd1073741824;
  localparam longint Q30_HALF = 64'sd536870912;

  localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  localparam logic [30:0] SC9 = 31'd172272;
  localparam logic [30:0] HORNER_C [4] = '{31'd5026995, 31'd85569306, 31'd693598669,
                                            31'd1686629713};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROLL  = 3'd0,
    REG_PITCH = 3'd1,
    REG_YAW   = 3'd2,
    REG_OFF_X = 3'd3,
    REG_OFF_Y = 3'd4,
    REG_OFF_Z = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [TRIG_W-1:0] cos_v;
  } trig_t;

  typedef struct packed {
    trig_t                     roll;
    trig_t                     pitch;
    trig_t                     yaw;
    logic signed [FIELD_W-1:0] off_x;
    logic signed [FIELD_W-1:0] off_y;
    logic signed [FIELD_W-1:0] off_z;
  } cfg_t;

endpackage

[rtl/core/lidar_point_transform_unit.sv]
// Top level of the lidar point transform.
// One return is taken per cycle whenever busy is low; its point appears on the
// point ports with done_o high, in order, and the receiver cannot stall: the
// strobe lasts one cycle. The path from accept to done_o runs through the
// seven-stage sine pipeline, the polar multiply and offset stages, two stages
// per axis rotation and the output saturation register. After reset and after
// every configuration write busy stays high while the mount-angle sines and
// cosines are re-evaluated by a shared pair of sine pipelines.
module lidar_point_transform_unit
  import lpt_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [FIELD_W-1:0]           beam_angle_i,
  input  logic [FIELD_W-1:0]           range_mm_i,
  input  logic signed [FIELD_W-1:0]    height_mm_i,
  output logic                         done_o,
  output logic signed [COORD_BITS-1:0] point_x_o,
  output logic signed [COORD_BITS-1:0] point_y_o,
  output logic signed [COORD_BITS-1:0] point_z_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [FIELD_W-1:0]           cfg_data_i
);

  localparam int PP_W = TRIG_W + FIELD_W + 1;
  localparam longint SAT_HI = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
  localparam longint SAT_LO = -SAT_HI - 64'sd1;

  cfg_t cfg;
  logic accept;
  logic [ANGLE_BITS-1:0] sin_in, cos_in;
  logic signed [TRIG_W-1:0] bsin, bcos;

  logic                      dv_q [SINE_LAT];
  logic [FIELD_W-1:0]        rng_q [SINE_LAT];
  logic signed [FIELD_W-1:0] hgt_q [SINE_LAT];

  logic p1v_q, p2v_q;
  logic signed [PP_W-1:0] px_q, py_q;
  logic signed [FIELD_W-1:0] pz_q;
  logic signed [CW-1:0] x2_q, y2_q, z2_q;
  logic signed [PP_W:0] rx, ry;

  logic rv, pv, yv;
  logic signed [CW-1:0] r_y, r_z, r_x, p_z, p_x, p_y, y_x, y_y, y_z;

  logic done_q;
  logic signed [COORD_BITS-1:0] ox_q, oy_q, oz_q;

  function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [CW-1:0] v);
    if (longint'(v) > SAT_HI) return COORD_BITS'(SAT_HI);
    if (longint'(v) < SAT_LO) return COORD_BITS'(SAT_LO);
    return COORD_BITS'(v);
  endfunction

  lpt_cfg u_cfg (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .cfg_o(cfg), .busy_o(busy)
  );

  assign accept = start && !busy;
  assign sin_in = ANGLE_BITS'(beam_angle_i);
  assign cos_in = sin_in + QUARTER_TURN;

  lpt_sine u_bsin (.clk_i, .angle_i(sin_in), .sine_o(bsin));
  lpt_sine u_bcos (.clk_i, .angle_i(cos_in), .sine_o(bcos));

  assign rx = {px_q[PP_W-1], px_q} + (PP_W+1)'(Q30_HALF);
  assign ry = {py_q[PP_W-1], py_q} + (PP_W+1)'(Q30_HALF);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SINE_LAT; i++) dv_q[i] <= 1'b0;
      p1v_q  <= 1'b0;
      p2v_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      dv_q[0] <= accept;
      for (int i = 1; i < SINE_LAT; i++) dv_q[i] <= dv_q[i-1];
      p1v_q  <= dv_q[SINE_LAT-1];
      p2v_q  <= p1v_q;
      done_q <= yv;
    end
  end

  always_ff @(posedge clk_i) begin
    rng_q[0] <= range_mm_i;
    hgt_q[0] <= height_mm_i;
    for (int i = 1; i < SINE_LAT; i++) begin
      rng_q[i] <= rng_q[i-1];
      hgt_q[i] <= hgt_q[i-1];
    end
    px_q <= $signed({1'b0, rng_q[SINE_LAT-1]}) * bcos;
    py_q <= $signed({1'b0, rng_q[SINE_LAT-1]}) * bsin;
    pz_q <= hgt_q[SINE_LAT-1];
    x2_q <= CW'(rx >>> 30) + CW'(cfg.off_x);
    y2_q <= CW'(ry >>> 30) + CW'(cfg.off_y);
    z2_q <= CW'(pz_q) + CW'(cfg.off_z);
    ox_q <= sat(y_x);
    oy_q <= sat(y_y);
    oz_q <= sat(y_z);
  end

  lpt_rotate u_roll (
    .clk_i, .rst_ni, .valid_i(p2v_q), .trig_i(cfg.roll),
    .a_i(y2_q), .b_i(z2_q), .c_i(x2_q),
    .valid_o(rv), .a_o(r_y), .b_o(r_z), .c_o(r_x)
  );

  lpt_rotate u_pitch (
    .clk_i, .rst_ni, .valid_i(rv), .trig_i(cfg.pitch),
    .a_i(r_z), .b_i(r_x), .c_i(r_y),
    .valid_o(pv), .a_o(p_z), .b_o(p_x), .c_o(p_y)
  );

  lpt_rotate u_yaw (
    .clk_i, .rst_ni, .valid_i(pv), .trig_i(cfg.yaw),
    .a_i(p_x), .b_i(p_y), .c_i(p_z),
    .valid_o(yv), .a_o(y_x), .b_o(y_y), .c_o(y_z)
  );

  assign done_o    = done_q;
  assign point_x_o = ox_q;
  assign point_y_o = oy_q;
  assign point_z_o = oz_q;

endmodule

[rtl/core/lpt_sine.sv]
// Pipelined Q30 sine of a binary angle: quadrant fold plus Horner polynomial.
module lpt_sine
  import lpt_pkg::*;
(
  input  logic                     clk_i,
  input  logic [ANGLE_BITS-1:0]    angle_i,
  output logic signed [TRIG_W-1:0] sine_o
);

  logic [23:0] phase;
  logic [29:0] frac;
  logic [30:0] t_d;

  logic [30:0] t_q   [6];
  logic        neg_q [6];
  logic [30:0] t2_q  [4];
  logic [30:0] s_q   [4];
  logic [30:0] s_in  [4];
  logic [61:0] prod  [4];
  logic [61:0] sq_prod;
  logic [61:0] fin_prod;
  logic [30:0] mag;
  logic signed [TRIG_W-1:0] sine_q;

  assign phase = 24'(angle_i) << (24 - ANGLE_BITS);
  assign frac  = {phase[21:0], 8'b0};
  assign t_d   = phase[22] ? 31'(Q30_ONE) - {1'b0, frac} : {1'b0, frac};

  assign sq_prod  = 62'(t_q[0]) * 62'(t_q[0]);
  assign fin_prod = 62'(t_q[5]) * 62'(s_q[3]);
  assign mag      = (fin_prod[60:30] > 31'(Q30_ONE)) ? 31'(Q30_ONE) : fin_prod[60:30];

  always_comb begin
    s_in[0] = SC9;
    for (int k = 1; k < 4; k++) s_in[k] = s_q[k-1];
    for (int k = 0; k < 4; k++) prod[k] = 62'(t2_q[k]) * 62'(s_in[k]);
  end

  always_ff @(posedge clk_i) begin
    t_q[0]   <= t_d;
    neg_q[0] <= phase[23];
    for (int i = 1; i < 6; i++) begin
      t_q[i]   <= t_q[i-1];
      neg_q[i] <= neg_q[i-1];
    end
    t2_q[0]  <= sq_prod[60:30];
    for (int k = 1; k < 4; k++) t2_q[k] <= t2_q[k-1];
    for (int k = 0; k < 4; k++) s_q[k] <= HORNER_C[k] - prod[k][60:30];
    sine_q   <= neg_q[5] ? -TRIG_W'($signed({1'b0, mag})) : TRIG_W'($signed({1'b0, mag}));
  end

  assign sine_o = sine_q;

endmodule

[rtl/core/lpt_cfg.sv]
// Configuration registers, shared trig evaluation of the mount angles, busy timer.
module lpt_cfg
  import lpt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [FIELD_W-1:0]   cfg_data_i,
  output cfg_t                 cfg_o,
  output logic                 busy_o
);

  typedef enum logic [1:0] {AX_ROLL, AX_PITCH, AX_YAW, AX_NONE} axis_e;

  logic [FIELD_W-1:0] roll_q, pitch_q, yaw_q;
  logic signed [FIELD_W-1:0] offx_q, offy_q, offz_q;
  axis_e rr_q;
  axis_e sel_q [SINE_LAT];
  logic [WARM_W-1:0] warm_q;
  logic [FIELD_W-1:0] ang_sel;
  logic [ANGLE_BITS-1:0] sin_in, cos_in;
  logic signed [TRIG_W-1:0] sin_out, cos_out;
  trig_t roll_t_q, pitch_t_q, yaw_t_q;
  logic wr;

  assign wr          = cfg_valid_i;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    unique case (rr_q)
      AX_ROLL:  ang_sel = roll_q;
      AX_PITCH: ang_sel = pitch_q;
      default:  ang_sel = yaw_q;
    endcase
  end

  assign sin_in = ANGLE_BITS'(ang_sel);
  assign cos_in = sin_in + QUARTER_TURN;

  lpt_sine u_sin (.clk_i, .angle_i(sin_in), .sine_o(sin_out));
  lpt_sine u_cos (.clk_i, .angle_i(cos_in), .sine_o(cos_out));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_q  <= '0;
      pitch_q <= '0;
      yaw_q   <= '0;
      offx_q  <= '0;
      offy_q  <= '0;
      offz_q  <= '0;
      rr_q    <= AX_ROLL;
      warm_q  <= WARM_W'(WARM_CYCLES);
      for (int i = 0; i < SINE_LAT; i++) sel_q[i] <= AX_NONE;
    end else begin
      if (wr) begin
        unique case (cfg_index_i)
          REG_ROLL:  roll_q  <= cfg_data_i;
          REG_PITCH: pitch_q <= cfg_data_i;
          REG_YAW:   yaw_q   <= cfg_data_i;
          REG_OFF_X: offx_q  <= cfg_data_i;
          REG_OFF_Y: offy_q  <= cfg_data_i;
          REG_OFF_Z: offz_q  <= cfg_data_i;
          default: ;
        endcase
        warm_q <= WARM_W'(WARM_CYCLES);
      end else if (warm_q != '0) begin
        warm_q <= warm_q - WARM_W'(1);
      end
      rr_q     <= (rr_q == AX_YAW) ? AX_ROLL : axis_e'(rr_q + 2'd1);
      sel_q[0] <= rr_q;
      for (int i = 1; i < SINE_LAT; i++) sel_q[i] <= sel_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (sel_q[SINE_LAT-1])
      AX_ROLL:  roll_t_q  <= '{sin_v: sin_out, cos_v: cos_out};
      AX_PITCH: pitch_t_q <= '{sin_v: sin_out, cos_v: cos_out};
      AX_YAW:   yaw_t_q   <= '{sin_v: sin_out, cos_v: cos_out};
      default: ;
    endcase
  end

  assign cfg_o = '{roll: roll_t_q, pitch: pitch_t_q, yaw: yaw_t_q,
                   off_x: offx_q, off_y: offy_q, off_z: offz_q};
  assign busy_o = (warm_q != '0);

endmodule

[rtl/core/lpt_rotate.sv]
// One plane rotation: products stage, then sum and round stage.
module lpt_rotate
  import lpt_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  trig_t                    trig_i,
  input  logic signed [CW-1:0]     a_i,
  input  logic signed [CW-1:0]     b_i,
  input  logic signed [CW-1:0]     c_i,
  output logic                     valid_o,
  output logic signed [CW-1:0]     a_o,
  output logic signed [CW-1:0]     b_o,
  output logic signed [CW-1:0]     c_o
);

  localparam int PW = TRIG_W + CW;

  logic signed [PW-1:0] ca_q, sb_q, sa_q, cb_q;
  logic signed [CW-1:0] c1_q, a2_q, b2_q, c2_q;
  logic v1_q, v2_q;
  logic signed [PW:0] na, nb;

  assign na = PW'(ca_q) - PW'(sb_q) + (PW+1)'(Q30_HALF);
  assign nb = PW'(sa_q) + PW'(cb_q) + (PW+1)'(Q30_HALF);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ca_q <= trig_i.cos_v * a_i;
    sb_q <= trig_i.sin_v * b_i;
    sa_q <= trig_i.sin_v * a_i;
    cb_q <= trig_i.cos_v * b_i;
    c1_q <= c_i;
    a2_q <= CW'(na >>> 30);
    b2_q <= CW'(nb >>> 30);
    c2_q <= c1_q;
  end

  assign valid_o = v2_q;
  assign a_o = a2_q;
  assign b_o = b2_q;
  assign c_o = c2_q;

endmodule

[rtl/core/lpt_checker.sv]
// Port-level checks for the lidar point transform, bound to the top level.
module lpt_checker
  import lpt_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input logic cfg_valid_i,
  input logic cfg_ready_o
);

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##PIPE_LAT done_o)
    else $error("accepted word not delivered after fixed latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, PIPE_LAT))
    else $error("result word without matching accepted word");

  a_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> busy)
    else $error("busy not raised after configuration write");

endmodule

bind lidar_point_transform_unit lpt_checker u_lpt_checker (
  .clk_i, .rst_ni, .start, .busy, .done_o, .cfg_valid_i, .cfg_ready_o
);
